// ===== rtl/core/hfd_pkg.sv =====
package hfd_pkg;

  // Configuration register map (index = paddr / 4)
  localparam int unsigned NUM_REGS = 6;
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned PADDR_W = 5;

  localparam logic [REG_IDX_W-1:0] REG_TEMP_SLOPE    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_TEMP_OFFSET   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_RH_SLOPE      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_RH_OFFSET     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_COMP_FACTOR   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_COMP_REF_TEMP = 3'd5;

  // Register reset values
  localparam logic [15:0] TEMP_SLOPE_RST    = 16'd22492;
  localparam logic [15:0] TEMP_OFFSET_RST   = 16'hE893;  // -5997
  localparam logic [15:0] RH_SLOPE_RST      = 16'd16000;
  localparam logic [15:0] RH_OFFSET_RST     = 16'hFD00;  // -768
  localparam logic [15:0] COMP_FACTOR_RST   = 16'd9830;
  localparam logic [15:0] COMP_REF_TEMP_RST = 16'd3200;

  // Frame kinds
  localparam logic OP_TEMP = 1'b0;
  localparam logic OP_HUM  = 1'b1;

  // Low two bits of the lsb byte are sensor status bits
  localparam logic [7:0] STATUS_MASK = 8'hFC;

  // CRC-8, poly 0x31, init 0: contribution of each bit of the 16-bit word
  localparam logic [7:0] CRC_COLS [16] = '{
    8'h31, 8'h62, 8'hC4, 8'hB9, 8'h43, 8'h86, 8'h3D, 8'h7A,
    8'hF4, 8'hD9, 8'h83, 8'h37, 8'h6E, 8'hDC, 8'h89, 8'h23
  };

  typedef struct packed {
    logic       opcode;
    logic [7:0] msb_byte;
    logic [7:0] lsb_byte;
    logic [7:0] crc_byte;
    logic       calibrate;
  } in_item_t;

  typedef struct packed {
    logic               status;
    logic signed [15:0] value;
    logic               compensated;
    logic               calib_publish;
  } out_item_t;

  // Classified frame handed from the front end to the back end
  typedef struct packed {
    logic        is_hum;
    logic        good;
    logic        calibrate;
    logic [13:0] raw;
  } job_t;

  typedef struct packed {
    logic        [15:0] temp_slope;
    logic signed [15:0] temp_offset;
    logic        [15:0] rh_slope;
    logic signed [15:0] rh_offset;
    logic        [15:0] comp_factor;
    logic signed [15:0] comp_ref_temp;
  } cfg_t;

  // Parallel CRC-8 over msb byte then lsb byte
  function automatic logic [7:0] crc8_16(input logic [15:0] data);
    logic [7:0] crc;
    crc = '0;
    for (int i = 0; i < 16; i++) begin
      if (data[i]) begin
        crc = crc ^ CRC_COLS[i];
      end
    end
    return crc;
  endfunction

endpackage

// ===== rtl/core/hfd_fifo.sv =====
module hfd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // Store incoming transaction
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/hfd_front.sv =====
module hfd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  hfd_pkg::in_item_t item,
  output logic              full,
  output logic              job_valid,
  output hfd_pkg::job_t     job,
  input  logic              job_full
);
  import hfd_pkg::*;

  logic       accept;
  logic [7:0] crc;
  job_t       job_in;

  // Check the frame and strip status bits
  assign crc              = crc8_16({item.msb_byte, item.lsb_byte});
  assign job_in.is_hum    = (item.opcode == OP_HUM);
  assign job_in.good      = (crc == item.crc_byte);
  assign job_in.calibrate = item.calibrate;
  assign job_in.raw       = {item.msb_byte, item.lsb_byte[7:2]};

  // Hold the classified frame until the queue takes it
  assign full   = job_valid && job_full;
  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else begin
      job_valid <= accept || (job_valid && job_full);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      job <= job_in;
    end
  end

endmodule

// ===== rtl/core/hfd_back.sv =====
module hfd_back #(
  parameter int unsigned OUT_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  hfd_pkg::cfg_t      cfg,
  input  logic               job_empty,
  input  hfd_pkg::job_t      job,
  output logic               job_pop,
  output logic               empty,
  input  logic               pop,
  output hfd_pkg::out_item_t result
);
  import hfd_pkg::*;

  // Multiply stage
  logic        m_valid;
  job_t        m_job;
  logic [31:0] m_prod;
  logic        m_ready;
  logic [15:0] slope;

  // Finish stage
  logic        w_valid;
  job_t        w_job;
  logic [31:0] w_prod;
  logic        w_ready;
  logic        w_done;
  logic        w_stall;

  // Stored temperature and compensation product
  logic signed [15:0] last_temperature;
  logic               temperature_usable;
  logic               comp_stale;
  logic signed [16:0] temp_diff;
  logic signed [33:0] comp_prod;

  logic signed [19:0] base;
  logic signed [19:0] offset;
  logic signed [19:0] comp_term;
  logic signed [19:0] sum;
  logic signed [15:0] sat;
  logic               use_comp;
  out_item_t          res;
  logic               o_full;

  // Handshake between stages
  assign w_stall = w_job.is_hum && w_job.good && temperature_usable && comp_stale;
  assign w_done  = w_valid && !o_full && !w_stall;
  assign w_ready = !w_valid || w_done;
  assign m_ready = !m_valid || w_ready;
  assign job_pop = !job_empty && m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      w_valid <= 1'b0;
    end else begin
      m_valid <= job_pop || (m_valid && !w_ready);
      w_valid <= (m_valid && w_ready) || (w_valid && !w_done);
    end
  end

  // Scale the raw reading
  assign slope = job.is_hum ? cfg.rh_slope : cfg.temp_slope;

  always_ff @(posedge clk) begin
    if (job_pop) begin
      m_job  <= job;
      m_prod <= {job.raw, 2'b00} * slope;
    end
  end

  always_ff @(posedge clk) begin
    if (m_valid && w_ready) begin
      w_job  <= m_job;
      w_prod <= m_prod;
    end
  end

  // Refresh the compensation product from the stored temperature
  assign temp_diff = 17'(cfg.comp_ref_temp) - 17'(last_temperature);

  always_ff @(posedge clk) begin
    comp_prod <= $signed({1'b0, cfg.comp_factor}) * temp_diff;
  end

  // Combine scale, offset and compensation, then saturate
  assign use_comp  = w_job.is_hum && temperature_usable;
  assign base      = $signed({4'b0000, w_prod[31:16]});
  assign offset    = w_job.is_hum ? 20'(cfg.rh_offset) : 20'(cfg.temp_offset);
  assign comp_term = use_comp ? 20'($signed(comp_prod[33:16])) : '0;
  assign sum       = base + offset - comp_term;

  always_comb begin
    if (sum > 20'sd32767) begin
      sat = 16'sh7FFF;
    end else if (sum < -20'sd32768) begin
      sat = 16'sh8000;
    end else begin
      sat = sum[15:0];
    end
  end

  always_comb begin
    res.status        = !w_job.good;
    res.value         = w_job.good ? sat : '0;
    res.compensated   = w_job.good && use_comp;
    res.calib_publish = w_job.good && !w_job.is_hum && w_job.calibrate;
  end

  // Update the stored temperature on finished temperature frames
  always_ff @(posedge clk) begin
    if (rst) begin
      last_temperature   <= '0;
      temperature_usable <= 1'b1;
      comp_stale         <= 1'b0;
    end else begin
      comp_stale <= w_done && !w_job.is_hum && w_job.good;
      if (w_done && !w_job.is_hum) begin
        temperature_usable <= w_job.good;
        if (w_job.good) begin
          last_temperature <= sat;
        end
      end
    end
  end

  // Result queue toward the consumer
  hfd_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (w_done),
    .wdata (res),
    .full  (o_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

endmodule

// ===== rtl/core/humidity_temp_frame_decode_core.sv =====
// Sensor frame decoder. Each pushed transaction is one received frame (two
// data bytes and a CRC-8 byte, tagged temperature or humidity); each frame
// yields exactly one result in order: a checksum status and the reading
// converted to signed Q.7 with the programmed slope and offset, humidity
// compensated against the last temperature if that frame was good. One frame
// is taken per cycle while the frame queue has room; a result passes the
// front register, frame queue, multiplier stage and finish stage. A good
// humidity frame that directly follows a good temperature frame waits in the
// finish stage while the compensation product is rebuilt from the new
// temperature. The output queue accepts results until it is full, which
// stalls the finish stage. Program registers over the APB port only while no
// frame is in flight; no clearing pass runs after reset.
module humidity_temp_frame_decode_core #(
  parameter int unsigned QUEUE_DEPTH = 4,
  parameter int unsigned OUT_DEPTH   = 2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  hfd_pkg::in_item_t             item,
  output logic                          full,
  input  logic                          pop,
  output hfd_pkg::out_item_t            result,
  output logic                          empty,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hfd_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import hfd_pkg::*;

  cfg_t                 cfg;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;
  logic                 job_valid;
  job_t                 job_f;
  job_t                 job_q;
  logic                 job_full;
  logic                 job_empty;
  logic                 job_pop;

  // Configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.temp_slope    <= TEMP_SLOPE_RST;
      cfg.temp_offset   <= TEMP_OFFSET_RST;
      cfg.rh_slope      <= RH_SLOPE_RST;
      cfg.rh_offset     <= RH_OFFSET_RST;
      cfg.comp_factor   <= COMP_FACTOR_RST;
      cfg.comp_ref_temp <= COMP_REF_TEMP_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_TEMP_SLOPE:    cfg.temp_slope    <= pwdata[15:0];
        REG_TEMP_OFFSET:   cfg.temp_offset   <= pwdata[15:0];
        REG_RH_SLOPE:      cfg.rh_slope      <= pwdata[15:0];
        REG_RH_OFFSET:     cfg.rh_offset     <= pwdata[15:0];
        REG_COMP_FACTOR:   cfg.comp_factor   <= pwdata[15:0];
        REG_COMP_REF_TEMP: cfg.comp_ref_temp <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (reg_idx)
      REG_TEMP_SLOPE:    prdata = {16'h0000, cfg.temp_slope};
      REG_TEMP_OFFSET:   prdata = {16'h0000, cfg.temp_offset};
      REG_RH_SLOPE:      prdata = {16'h0000, cfg.rh_slope};
      REG_RH_OFFSET:     prdata = {16'h0000, cfg.rh_offset};
      REG_COMP_FACTOR:   prdata = {16'h0000, cfg.comp_factor};
      REG_COMP_REF_TEMP: prdata = {16'h0000, cfg.comp_ref_temp};
      default:           prdata = '0;
    endcase
  end

  // Front end: accept and classify frames
  hfd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .item      (item),
    .full      (full),
    .job_valid (job_valid),
    .job       (job_f),
    .job_full  (job_full)
  );

  // Frame queue between front and back
  hfd_fifo #(
    .WIDTH ($bits(job_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .push  (job_valid),
    .wdata (job_f),
    .full  (job_full),
    .pop   (job_pop),
    .rdata (job_q),
    .empty (job_empty)
  );

  // Back end: convert, compensate and queue results
  hfd_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_empty (job_empty),
    .job       (job_q),
    .job_pop   (job_pop),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule

// ===== verif/hfd_crc_pkg.sv =====
package hfd_crc_pkg;

  // Serial CRC-8, poly 0x31, init 0, msb byte first, msb bit first
  function automatic logic [7:0] sensor_crc8(input logic [7:0] msb, input logic [7:0] lsb);
    logic [15:0] word;
    logic [7:0]  crc;
    word = {msb, lsb};
    crc  = 8'h00;
    for (int i = 15; i >= 0; i--) begin
      if (crc[7] ^ word[i]) begin
        crc = {crc[6:0], 1'b0} ^ 8'h31;
      end else begin
        crc = {crc[6:0], 1'b0};
      end
    end
    return crc;
  endfunction

endpackage

// ===== verif/hfd_conversion_checker.sv =====
module hfd_conversion_checker
  import hfd_pkg::*;
  import hfd_crc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  in_item_t           item,
  input  logic               full,
  input  logic               pop,
  input  out_item_t          result,
  input  logic               empty,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 mismatches,
  output int                 outstanding
);

  // Mirror of the programmed conversion settings
  cfg_t               conv_cfg;
  // Last good temperature and whether humidity may be compensated by it
  logic signed [15:0] stored_temp;
  logic               stored_temp_ok;
  // Readings the block still owes, oldest first
  out_item_t          owed_readings[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic logic signed [15:0] clamp_q7(input longint x);
    if (x > 32767) begin
      return 16'sh7FFF;
    end else if (x < -32768) begin
      return 16'sh8000;
    end
    return x[15:0];
  endfunction

  // Decode one frame and advance the stored temperature state
  function automatic out_item_t decode_frame(input in_item_t f);
    logic [15:0] raw;
    logic [31:0] prod;
    longint      acc;
    longint      diff;
    out_item_t   r;
    raw = {f.msb_byte, f.lsb_byte & 8'hFC};
    r   = '0;
    if (sensor_crc8(f.msb_byte, f.lsb_byte) != f.crc_byte) begin
      r.status = 1'b1;
      if (f.opcode == OP_TEMP) begin
        stored_temp_ok = 1'b0;
      end
    end else if (f.opcode == OP_TEMP) begin
      prod           = {16'd0, raw} * {16'd0, conv_cfg.temp_slope};
      acc            = longint'(prod[31:16]) + longint'(conv_cfg.temp_offset);
      r.value        = clamp_q7(acc);
      r.calib_publish = f.calibrate;
      stored_temp    = r.value;
      stored_temp_ok = 1'b1;
    end else begin
      prod = {16'd0, raw} * {16'd0, conv_cfg.rh_slope};
      acc  = longint'(prod[31:16]) + longint'(conv_cfg.rh_offset);
      if (stored_temp_ok) begin
        diff          = longint'(conv_cfg.comp_ref_temp) - longint'(stored_temp);
        // Arithmetic shift floors toward minus infinity
        acc           = acc - ((longint'(conv_cfg.comp_factor) * diff) >>> 16);
        r.compensated = 1'b1;
      end
      r.value = clamp_q7(acc);
    end
    return r;
  endfunction

  // Track register writes, compare popped readings, predict pushed frames
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      conv_cfg.temp_slope    = 16'd22492;
      conv_cfg.temp_offset   = -16'sd5997;
      conv_cfg.rh_slope      = 16'd16000;
      conv_cfg.rh_offset     = -16'sd768;
      conv_cfg.comp_factor   = 16'd9830;
      conv_cfg.comp_ref_temp = 16'sd3200;
      stored_temp            = '0;
      stored_temp_ok         = 1'b1;
      owed_readings.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[PADDR_W-1:2])
          REG_TEMP_SLOPE:    conv_cfg.temp_slope    = pwdata[15:0];
          REG_TEMP_OFFSET:   conv_cfg.temp_offset   = pwdata[15:0];
          REG_RH_SLOPE:      conv_cfg.rh_slope      = pwdata[15:0];
          REG_RH_OFFSET:     conv_cfg.rh_offset     = pwdata[15:0];
          REG_COMP_FACTOR:   conv_cfg.comp_factor   = pwdata[15:0];
          REG_COMP_REF_TEMP: conv_cfg.comp_ref_temp = pwdata[15:0];
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (owed_readings.size() == 0) begin
          $display("%0t unexpected result transaction: %p", $time, result);
          mismatches++;
        end else begin
          want = owed_readings.pop_front();
          if (result.status !== want.status) begin
            $display("%0t status: expected %0d actual %0d", $time, want.status, result.status);
            mismatches++;
          end
          if (result.value !== want.value) begin
            $display("%0t value: expected %0d actual %0d", $time, want.value, result.value);
            mismatches++;
          end
          if (result.compensated !== want.compensated) begin
            $display("%0t compensated: expected %0d actual %0d", $time,
                     want.compensated, result.compensated);
            mismatches++;
          end
          if (result.calib_publish !== want.calib_publish) begin
            $display("%0t calib_publish: expected %0d actual %0d", $time,
                     want.calib_publish, result.calib_publish);
            mismatches++;
          end
        end
      end
      if (push && !full) begin
        owed_readings.push_back(decode_frame(item));
      end
    end
    outstanding = owed_readings.size();
  end

endmodule

// ===== verif/tb_humidity_temp_frame_decode_core.sv =====
module tb_humidity_temp_frame_decode_core;
  import hfd_pkg::*;
  import hfd_crc_pkg::*;

  localparam int NUM_PHASES      = 10;
  localparam int ITEMS_PER_PHASE = 103;
  localparam int HOLD_PHASE      = 4;
  localparam int HOLD_CYCLES     = 300;

  logic               clk     = 1'b0;
  logic               rst     = 1'b1;
  logic               push    = 1'b0;
  in_item_t           item    = '0;
  logic               full;
  logic               pop     = 1'b0;
  out_item_t          result;
  logic               empty;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [31:0]        pwdata  = '0;
  logic [31:0]        prdata;
  logic               pready;

  int                 mismatches;
  int                 outstanding;
  // Receiver controls: one long hold-off, and no idling near the end
  bit                 hold_req  = 1'b0;
  bit                 hold_done = 1'b0;
  bit                 calm      = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  humidity_temp_frame_decode_core u_top (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .item    (item),
    .full    (full),
    .pop     (pop),
    .result  (result),
    .empty   (empty),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  hfd_conversion_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .item        (item),
    .full        (full),
    .pop         (pop),
    .result      (result),
    .empty       (empty),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  function automatic in_item_t build_frame(input logic op, input logic [7:0] msb,
                                           input logic [7:0] lsb, input logic cal,
                                           input logic [7:0] crc_flip);
    in_item_t f;
    f.opcode    = op;
    f.msb_byte  = msb;
    f.lsb_byte  = lsb;
    f.calibrate = cal;
    f.crc_byte  = sensor_crc8(msb, lsb) ^ crc_flip;
    return f;
  endfunction

  // Lean toward the all-zero and all-one bytes
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly good frames, about one in five with a corrupted checksum
  function automatic in_item_t random_frame();
    logic [7:0] flip;
    flip = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
    return build_frame(($urandom_range(0, 1) == 1) ? OP_HUM : OP_TEMP, pick_byte(),
                       pick_byte(), 1'($urandom_range(0, 1)), flip);
  endfunction

  // Offer one frame and hold it until the block takes it
  task automatic send_frame(input in_item_t f);
    push <= 1'b1;
    item <= f;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Stop offering and wait until every owed reading has been popped
  task automatic wait_drained();
    push <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  // Setup then access cycle; the caller drops psel after the last write
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [15:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom), v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic program_phase(input int p);
    logic [15:0] v [6];
    case (p)
      1: v = '{16'hFFFF, 16'h7FFF, 16'hFFFF, 16'h7FFF, 16'hFFFF, 16'h7FFF};
      2: v = '{16'h0000, 16'h8000, 16'h0000, 16'h8000, 16'h0000, 16'h8000};
      3: v = '{16'hFFFF, 16'h8000, 16'hFFFF, 16'h8000, 16'hFFFF, 16'h8000};
      NUM_PHASES - 1: v = '{16'd22492, 16'hE893, 16'd16000, 16'hFD00, 16'd9830, 16'd3200};
      default: begin
        for (int i = 0; i < 6; i++) begin
          v[i] = 16'($urandom);
        end
      end
    endcase
    write_reg(REG_TEMP_SLOPE,    v[0]);
    write_reg(REG_TEMP_OFFSET,   v[1]);
    write_reg(REG_RH_SLOPE,      v[2]);
    write_reg(REG_RH_OFFSET,     v[3]);
    write_reg(REG_COMP_FACTOR,   v[4]);
    write_reg(REG_COMP_REF_TEMP, v[5]);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_directed();
    // Extremes, status bits ignored, humidity compensated
    send_frame(build_frame(OP_TEMP, 8'h00, 8'h00, 1'b1, 8'h00));
    send_frame(build_frame(OP_TEMP, 8'hFF, 8'hFF, 1'b0, 8'h00));
    send_frame(build_frame(OP_TEMP, 8'hFF, 8'hFC, 1'b1, 8'h00));
    send_frame(build_frame(OP_HUM,  8'h00, 8'h00, 1'b0, 8'h00));
    send_frame(build_frame(OP_HUM,  8'hFF, 8'hFF, 1'b1, 8'h00));
    send_frame(build_frame(OP_HUM,  8'h80, 8'h03, 1'b0, 8'h00));
    // Bad temperature checksum leaves humidity uncompensated
    send_frame(build_frame(OP_TEMP, 8'h66, 8'h5C, 1'b1, 8'h01));
    send_frame(build_frame(OP_HUM,  8'h7C, 8'h80, 1'b0, 8'h00));
    send_frame(build_frame(OP_HUM,  8'h12, 8'h34, 1'b0, 8'h80));
    send_frame(build_frame(OP_HUM,  8'h00, 8'h00, 1'b1, 8'h00));
    // Good temperature restores compensation, humidity right behind it
    send_frame(build_frame(OP_TEMP, 8'h66, 8'h5C, 1'b0, 8'h00));
    send_frame(build_frame(OP_HUM,  8'h7C, 8'h80, 1'b0, 8'h00));
    send_frame(build_frame(OP_TEMP, 8'h00, 8'h00, 1'b1, 8'hFF));
    send_frame(build_frame(OP_TEMP, 8'h80, 8'h00, 1'b1, 8'h00));
    send_frame(build_frame(OP_HUM,  8'hFF, 8'hFF, 1'b0, 8'h01));
    send_frame(build_frame(OP_TEMP, 8'h55, 8'hAA, 1'b1, 8'h00));
    send_frame(build_frame(OP_HUM,  8'h55, 8'hAA, 1'b1, 8'h00));
    send_frame(build_frame(OP_TEMP, 8'hAA, 8'h55, 1'b1, 8'h00));
    send_frame(build_frame(OP_HUM,  8'hAA, 8'h57, 1'b0, 8'h00));
    send_frame(build_frame(OP_TEMP, 8'h3C, 8'h00, 1'b0, 8'h00));
    send_frame(build_frame(OP_HUM,  8'h00, 8'h03, 1'b0, 8'h00));
  endtask

  // Receiver: random pop bursts, one long hold-off on request
  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        pop       <= 1'b0;
        hold_done = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        pop <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // Sender: reset, directed frames, then random phases over several settings
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 0) begin
        run_directed();
      end else begin
        wait_drained();
        program_phase(p);
      end
      if (p == HOLD_PHASE) begin
        hold_req = 1'b1;
      end
      if (p == NUM_PHASES - 1) begin
        calm = 1'b1;
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (!calm && $urandom_range(0, 5) == 0) begin
          push <= 1'b0;
          repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        send_frame(random_frame());
      end
    end
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_humidity_temp_frame_decode_core: PASS");
    end else begin
      $display("tb_humidity_temp_frame_decode_core: FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("tb_humidity_temp_frame_decode_core: FAIL");
    $finish;
  end

endmodule
